>>> rtl/core/anns_pkg.sv
// shared types, codes and constants for the angular nearest-neighbor store
// no dependencies
package anns_pkg;

   localparam int CAPACITY_DEFAULT   = 64;
   localparam int MAX_JOINTS_DEFAULT = 7;
   localparam int ANGLE_BITS_DEFAULT = 16;

   localparam int NUM_JOINT_PORTS = 7;
   localparam int ANGLE_PORT_BITS = 16;
   localparam int SLOT_PORT_BITS  = 6;
   localparam int DIST_BITS       = 33;
   localparam int DOF_BITS        = 3;
   localparam int PIPE_LATENCY    = 4;

   localparam logic [DIST_BITS-1:0] DIST_MAX  = {DIST_BITS{1'b1}};
   localparam logic [DOF_BITS-1:0]  DOF_RESET = 3'd7;

   typedef logic [ANGLE_PORT_BITS-1:0] angle_type;

   typedef enum logic [1:0] {
      KIND_INSERT  = 2'd0,
      KIND_NEAREST = 2'd1,
      KIND_RADIUS  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } state_type;

endpackage

>>> rtl/core/anns_cell.sv
// one storage cell of the rotating table: holds one joint configuration
// depends on anns_pkg
module anns_cell #(
   parameter int MAX_JOINTS = anns_pkg::MAX_JOINTS_DEFAULT
) (
   input  logic               clock,
   input  logic               shift_en,
   input  logic               load_en,
   input  anns_pkg::angle_type load_data  [MAX_JOINTS],
   input  anns_pkg::angle_type shift_data [MAX_JOINTS],
   output anns_pkg::angle_type entry_out  [MAX_JOINTS]
);

   anns_pkg::angle_type entry_ff [MAX_JOINTS];
   anns_pkg::angle_type entry_in [MAX_JOINTS];

   always_comb begin
      for (int j = 0; j < MAX_JOINTS; j++) begin
         if (load_en) begin
            entry_in[j] = load_data[j];
         end else if (shift_en) begin
            entry_in[j] = shift_data[j];
         end else begin
            entry_in[j] = entry_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

>>> rtl/core/anns_dist.sv
// four-stage distance pipe: wrapped angle difference, square, partial sums,
// total with saturation; depends on anns_pkg
module anns_dist #(
   parameter int MAX_JOINTS = anns_pkg::MAX_JOINTS_DEFAULT,
   parameter int ANGLE_BITS = anns_pkg::ANGLE_BITS_DEFAULT,
   parameter int SLOT_W     = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              feed_valid,
   input  logic [SLOT_W-1:0]                 feed_slot,
   input  anns_pkg::angle_type               entry   [MAX_JOINTS],
   input  anns_pkg::angle_type               query   [MAX_JOINTS],
   input  logic [anns_pkg::DOF_BITS-1:0]     dof_count,
   output logic                              dist_valid,
   output logic [SLOT_W-1:0]                 dist_slot,
   output logic [anns_pkg::DIST_BITS-1:0]    dist_value
);

   localparam int AB       = ANGLE_BITS;
   localparam int WW       = (AB > 17) ? AB : 17;
   localparam int MAG_BITS = (AB < 16) ? AB : 16;
   localparam int SQ_BITS  = 2 * MAG_BITS;
   localparam int SUM_W    = SQ_BITS + 3;
   localparam int EXT_W    = (SUM_W > anns_pkg::DIST_BITS) ? SUM_W : anns_pkg::DIST_BITS;

   logic [MAG_BITS-1:0] mag_ff [MAX_JOINTS];
   logic [MAG_BITS-1:0] mag_in [MAX_JOINTS];
   logic [SQ_BITS-1:0]  sq_ff  [MAX_JOINTS];
   logic [SUM_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [anns_pkg::DIST_BITS-1:0] total_ff, total_in;

   logic [3:0] valid_ff;
   logic [SLOT_W-1:0] slot1_ff, slot2_ff, slot3_ff, slot4_ff;

   // stage 1: difference wrapped at the angle width, then magnitude
   always_comb begin
      logic [WW-1:0] a_ext;
      logic [WW-1:0] b_ext;
      logic [WW-1:0] diff;
      logic [AB-1:0] d;
      logic [AB-1:0] m;
      for (int j = 0; j < MAX_JOINTS; j++) begin
         a_ext = {{(WW-16){entry[j][15]}}, entry[j]};
         b_ext = {{(WW-16){query[j][15]}}, query[j]};
         diff  = a_ext - b_ext;
         d     = diff[AB-1:0];
         m     = d[AB-1] ? AB'(~d + 1'b1) : d;
         // joints past dof_count add nothing
         mag_in[j] = (3'(j) < dof_count) ? m[MAG_BITS-1:0] : '0;
      end
   end

   // stage 3: two partial sums
   always_comb begin
      lo_in = '0;
      hi_in = '0;
      for (int j = 0; j < MAX_JOINTS; j++) begin
         if (j < 4) begin
            lo_in = lo_in + SUM_W'(sq_ff[j]);
         end else begin
            hi_in = hi_in + SUM_W'(sq_ff[j]);
         end
      end
   end

   // stage 4: total, saturating at the distance width
   always_comb begin
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(lo_ff) + EXT_W'(hi_ff);
      if (ext > EXT_W'(anns_pkg::DIST_MAX)) begin
         total_in = anns_pkg::DIST_MAX;
      end else begin
         total_in = ext[anns_pkg::DIST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      for (int j = 0; j < MAX_JOINTS; j++) begin
         sq_ff[j] <= mag_ff[j] * mag_ff[j];
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      total_ff <= total_in;
      slot1_ff <= feed_slot;
      slot2_ff <= slot1_ff;
      slot3_ff <= slot2_ff;
      slot4_ff <= slot3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], feed_valid};
      end
   end

   assign dist_valid = valid_ff[3];
   assign dist_slot  = slot4_ff;
   assign dist_value = total_ff;

endmodule

>>> rtl/core/angular_nearest_neighbor_store_unit.sv
// top level of the angular nearest-neighbor store: rotating ring of cells,
// distance pipe, scan control and result register; depends on anns_pkg,
// anns_cell and anns_dist
//
// An insert is answered on rsp_ the cycle after start is taken and busy
// stays low, so items may follow back to back. A nearest or radius query
// raises busy while the ring of cells rotates once (one stored entry
// through the distance pipe per cycle), the four-stage distance pipe
// drains, and the final beat is formed.
// Radius hits come out at most one beat per cycle while the scan runs, each
// one the cycle after the next hit is seen; the last beat follows the end of
// the scan. Results are held for one cycle only and cannot be stalled, so the
// receiver must take every beat with rsp_strobe high.
module angular_nearest_neighbor_store_unit #(
   parameter int CAPACITY   = anns_pkg::CAPACITY_DEFAULT,
   parameter int MAX_JOINTS = anns_pkg::MAX_JOINTS_DEFAULT,
   parameter int ANGLE_BITS = anns_pkg::ANGLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_kind,
   input  logic signed [15:0]                   req_joint_0,
   input  logic signed [15:0]                   req_joint_1,
   input  logic signed [15:0]                   req_joint_2,
   input  logic signed [15:0]                   req_joint_3,
   input  logic signed [15:0]                   req_joint_4,
   input  logic signed [15:0]                   req_joint_5,
   input  logic signed [15:0]                   req_joint_6,
   input  logic [anns_pkg::DIST_BITS-1:0]       req_radius_sq,
   output logic                                 rsp_strobe,
   output logic [anns_pkg::SLOT_PORT_BITS-1:0]  rsp_slot_index,
   output logic [anns_pkg::DIST_BITS-1:0]       rsp_distance_sq,
   output logic                                 rsp_found,
   output logic                                 rsp_last,
   output logic [1:0]                           rsp_status,
   input  logic                                 csr_write_enable,
   input  logic [anns_pkg::DOF_BITS-1:0]        csr_write_data
);

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int CNT_W  = $clog2(CAPACITY + anns_pkg::PIPE_LATENCY + 1);
   localparam logic [CNT_W-1:0] SHIFT_END = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(CAPACITY + anns_pkg::PIPE_LATENCY);

   anns_pkg::angle_type req_joints [anns_pkg::NUM_JOINT_PORTS];
   anns_pkg::angle_type load_data  [MAX_JOINTS];
   anns_pkg::angle_type cell_data  [CAPACITY][MAX_JOINTS];

   anns_pkg::state_type  state_ff, state_in;
   anns_pkg::kind_type   kind_ff, kind_in, req_kind_t;
   anns_pkg::status_type status_ff, status_in;

   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [anns_pkg::DOF_BITS-1:0] dof_ff, dof_in;
   anns_pkg::angle_type query_ff [MAX_JOINTS];
   anns_pkg::angle_type query_in [MAX_JOINTS];
   logic [anns_pkg::DIST_BITS-1:0] radius_ff, radius_in;

   logic                           hold_valid_ff, hold_valid_in;
   logic [SLOT_W-1:0]              hold_slot_ff, hold_slot_in;
   logic [anns_pkg::DIST_BITS-1:0] hold_dist_ff, hold_dist_in;

   logic                           strobe_ff, strobe_in;
   logic [SLOT_W-1:0]              slot_ff, slot_in;
   logic [anns_pkg::DIST_BITS-1:0] dist_ff, dist_in;
   logic                           found_ff, found_in;
   logic                           last_ff, last_in;

   logic accept, is_full, is_empty, insert_ok, query_ok;
   logic shift_en, feed_valid, finish;
   logic [SLOT_W-1:0] insert_slot;

   logic                           dist_valid;
   logic [SLOT_W-1:0]              dist_slot;
   logic [anns_pkg::DIST_BITS-1:0] dist_value;
   logic hit, better;

   assign req_joints[0] = req_joint_0;
   assign req_joints[1] = req_joint_1;
   assign req_joints[2] = req_joint_2;
   assign req_joints[3] = req_joint_3;
   assign req_joints[4] = req_joint_4;
   assign req_joints[5] = req_joint_5;
   assign req_joints[6] = req_joint_6;

   always_comb begin
      for (int j = 0; j < MAX_JOINTS; j++) begin
         load_data[j] = req_joints[j];
      end
   end

   assign req_kind_t  = anns_pkg::kind_type'(req_kind);
   assign accept      = start && !busy;
   assign is_full     = (count_ff >= CW'(CAPACITY));
   assign is_empty    = (count_ff == '0);
   assign insert_slot = count_ff[SLOT_W-1:0];
   assign insert_ok   = accept && (req_kind_t == anns_pkg::KIND_INSERT) && !is_full;
   assign query_ok    = accept && !is_empty &&
                        ((req_kind_t == anns_pkg::KIND_NEAREST) ||
                         (req_kind_t == anns_pkg::KIND_RADIUS));

   // ring of cells: cell i takes cell i+1, cell 0 feeds the distance pipe
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      anns_cell #(
         .MAX_JOINTS(MAX_JOINTS)
      ) u_cell (
         .clock     (clock),
         .shift_en  (shift_en),
         .load_en   (insert_ok && (insert_slot == SLOT_W'(i))),
         .load_data (load_data),
         .shift_data(cell_data[(i + 1) % CAPACITY]),
         .entry_out (cell_data[i])
      );
   end

   anns_dist #(
      .MAX_JOINTS(MAX_JOINTS),
      .ANGLE_BITS(ANGLE_BITS),
      .SLOT_W    (SLOT_W)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .feed_valid(feed_valid),
      .feed_slot (scan_ff[SLOT_W-1:0]),
      .entry     (cell_data[0]),
      .query     (query_ff),
      .dof_count (dof_ff),
      .dist_valid(dist_valid),
      .dist_slot (dist_slot),
      .dist_value(dist_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         anns_pkg::ST_IDLE: begin
            if (query_ok) begin
               state_in = anns_pkg::ST_SCAN;
            end
         end
         anns_pkg::ST_SCAN: begin
            if (scan_ff == SCAN_END) begin
               state_in = anns_pkg::ST_IDLE;
            end
         end
         default: state_in = anns_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      busy       = 1'b0;
      shift_en   = 1'b0;
      feed_valid = 1'b0;
      finish     = 1'b0;
      unique case (state_ff)
         anns_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         anns_pkg::ST_SCAN: begin
            busy       = 1'b1;
            shift_en   = (scan_ff < SHIFT_END);
            feed_valid = (scan_ff < CNT_W'(count_ff));
            finish     = (scan_ff == SCAN_END);
         end
         default: busy = 1'b0;
      endcase
   end

   assign hit    = dist_valid && (kind_ff == anns_pkg::KIND_RADIUS) &&
                   (dist_value < radius_ff);
   assign better = dist_valid && (kind_ff == anns_pkg::KIND_NEAREST) &&
                   (!hold_valid_ff || (dist_value < hold_dist_ff));

   always_comb begin
      scan_in   = (state_ff == anns_pkg::ST_SCAN) ? scan_ff + 1'b1 : scan_ff;
      count_in  = insert_ok ? count_ff + 1'b1 : count_ff;
      dof_in    = csr_write_enable ? csr_write_data : dof_ff;
      kind_in   = kind_ff;
      query_in  = query_ff;
      radius_in = radius_ff;
      if (query_ok) begin
         scan_in   = '0;
         kind_in   = req_kind_t;
         query_in  = load_data;
         radius_in = req_radius_sq;
      end
   end

   // hold keeps the best so far, or the radius hit not yet sent
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_slot_in  = hold_slot_ff;
      hold_dist_in  = hold_dist_ff;
      priority if (query_ok) begin
         hold_valid_in = 1'b0;
      end else if (hit || better) begin
         hold_valid_in = 1'b1;
         hold_slot_in  = dist_slot;
         hold_dist_in  = dist_value;
      end
   end

   always_comb begin
      strobe_in = 1'b0;
      slot_in   = '0;
      dist_in   = '0;
      found_in  = 1'b0;
      last_in   = 1'b1;
      status_in = anns_pkg::STATUS_OK;
      priority if (accept) begin
         unique case (req_kind_t)
            anns_pkg::KIND_INSERT: begin
               strobe_in = 1'b1;
               if (is_full) begin
                  status_in = anns_pkg::STATUS_FULL;
               end else begin
                  slot_in  = insert_slot;
                  found_in = 1'b1;
               end
            end
            anns_pkg::KIND_NEAREST, anns_pkg::KIND_RADIUS: begin
               if (is_empty) begin
                  strobe_in = 1'b1;
                  status_in = anns_pkg::STATUS_EMPTY;
               end
            end
            default: strobe_in = 1'b0;
         endcase
      end else if (finish) begin
         strobe_in = 1'b1;
         if (hold_valid_ff) begin
            slot_in  = hold_slot_ff;
            dist_in  = hold_dist_ff;
            found_in = 1'b1;
         end
      end else if (hit && hold_valid_ff) begin
         // a newer hit proves the held one is not the last beat
         strobe_in = 1'b1;
         slot_in   = hold_slot_ff;
         dist_in   = hold_dist_ff;
         found_in  = 1'b1;
         last_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= anns_pkg::ST_IDLE;
         scan_ff       <= '0;
         count_ff      <= '0;
         dof_ff        <= anns_pkg::DOF_RESET;
         kind_ff       <= anns_pkg::KIND_INSERT;
         hold_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         count_ff      <= count_in;
         dof_ff        <= dof_in;
         kind_ff       <= kind_in;
         hold_valid_ff <= hold_valid_in;
         strobe_ff     <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff     <= query_in;
      radius_ff    <= radius_in;
      hold_slot_ff <= hold_slot_in;
      hold_dist_ff <= hold_dist_in;
      slot_ff      <= slot_in;
      dist_ff      <= dist_in;
      found_ff     <= found_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_slot_index  = anns_pkg::SLOT_PORT_BITS'(slot_ff);
   assign rsp_distance_sq = dist_ff;
   assign rsp_found       = found_ff;
   assign rsp_last        = last_ff;
   assign rsp_status      = status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");

   a_query_busy : assert property (@(posedge clock) disable iff (reset)
      query_ok |=> busy && (scan_ff == '0))
      else $error("query accepted without starting a scan");

   a_mid_beat_radius : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> (kind_ff == anns_pkg::KIND_RADIUS) && rsp_found)
      else $error("non-final beat outside a radius query");

   a_no_beat_past_pipe : assert property (@(posedge clock) disable iff (reset)
      (busy && (scan_ff < CNT_W'(anns_pkg::PIPE_LATENCY + 1))) |-> !rsp_strobe)
      else $error("beat before the distance pipe produced data");

endmodule
